FILE: design/bpab_pkg.sv
// Shared types and constants for the branch predictor accuracy bank.
`default_nettype none

package bpab_pkg;

	localparam int PC_W       = 31;
	localparam int TGT_W      = 32;
	localparam int CNT_W      = 32;
	localparam int CTR_W      = 2;
	localparam int FIFO_DEPTH = 2;

	localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
	localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;

	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic             taken;
		logic [TGT_W-1:0] target;
		logic             static_hit;
		logic             global_hit;
	} front_item_t;

	typedef struct packed {
		logic [TGT_W-1:0] target;
		logic [CTR_W-1:0] ctr;
		logic             one_bit;
	} entry_t;

	localparam entry_t ENTRY_INIT = '{target: '0, ctr: CTR_WEAK_TAKEN, one_bit: 1'b1};

	typedef struct packed {
		logic             static_hit;
		logic             global_hit;
		logic             one_bit_hit;
		logic             two_bit_hit;
		logic             target_hit;
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] static_cnt;
		logic [CNT_W-1:0] global_cnt;
		logic [CNT_W-1:0] one_bit_cnt;
		logic [CNT_W-1:0] two_bit_cnt;
		logic [CNT_W-1:0] target_cnt;
	} result_t;

	typedef struct packed {
		logic clearing;
		logic in_pop;
	} back_status_t;

endpackage

`default_nettype wire

FILE: design/bpab_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none

module bpab_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  item_t push_item,
	output logic  full,
	input  wire   pop,
	output item_t pop_item,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: design/bpab_front.sv
// Front end: accepts branches, scores the static and global predictors.
`default_nettype none

module bpab_front (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            push,
	output logic                           full,
	input  wire  [bpab_pkg::PC_W-1:0]      branch_pc,
	input  wire                            was_taken,
	input  wire  [bpab_pkg::TGT_W-1:0]     branch_target,
	input  wire                            mid_full,
	input  wire                            clearing,
	output logic                           mid_push,
	output bpab_pkg::front_item_t          mid_item
);

	import bpab_pkg::*;

	logic last_outcome_q;

	assign full     = mid_full || clearing;
	assign mid_push = push && !full;

	always_comb begin
		mid_item.pc         = branch_pc;
		mid_item.taken      = was_taken;
		mid_item.target     = branch_target;
		mid_item.static_hit = was_taken;
		mid_item.global_hit = (last_outcome_q == was_taken);
	end

	// track the last outcome in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_outcome_q <= 1'b1;
		end else if (mid_push) begin
			last_outcome_q <= was_taken;
		end
	end

endmodule

`default_nettype wire

FILE: design/bpab_back.sv
// Back end: per-index table, forwarding, hit counters and table clear after reset.
`default_nettype none

module bpab_back #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	input  bpab_pkg::front_item_t          in_item,
	output bpab_pkg::back_status_t         status,
	input  wire                            out_full,
	output logic                           out_push,
	output bpab_pkg::result_t              out_item
);

	import bpab_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

	entry_t             mem [TABLE_ENTRIES];

	logic               clearing_q;
	logic [IDX_W-1:0]   clr_idx_q;

	logic               valid_s2;
	front_item_t        item_s2;
	logic [IDX_W-1:0]   idx_s2;
	entry_t             rdata_s2;

	logic               fwd_valid_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	entry_t             fwd_data_q;

	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   static_q;
	logic [CNT_W-1:0]   global_q;
	logic [CNT_W-1:0]   one_bit_q;
	logic [CNT_W-1:0]   two_bit_q;
	logic [CNT_W-1:0]   target_q;

	logic               retire;
	logic               load;
	logic [IDX_W-1:0]   in_idx;
	entry_t             cur;
	entry_t             upd;
	logic               one_bit_hit;
	logic               two_bit_hit;
	logic               target_hit;

	assign in_idx = in_item.pc[IDX_W-1:0] & IDX_MASK;
	assign retire = valid_s2 && !out_full;
	assign load   = in_valid && !clearing_q && (!valid_s2 || retire);

	assign status.clearing = clearing_q;
	assign status.in_pop   = load;

	always_comb begin
		cur = ((fwd_valid_q && (fwd_idx_q == idx_s2)) ? fwd_data_q : rdata_s2);
		one_bit_hit = (cur.one_bit == item_s2.taken);
		two_bit_hit = (cur.ctr[CTR_W-1] == item_s2.taken);
		target_hit  = (cur.target == item_s2.target);

		upd.one_bit = item_s2.taken;
		upd.target  = item_s2.target;
		upd.ctr     = cur.ctr;
		if (item_s2.taken) begin
			if (cur.ctr != CTR_MAX) begin
				upd.ctr = cur.ctr + 1'b1;
			end
		end else begin
			if (cur.ctr != CTR_MIN) begin
				upd.ctr = cur.ctr - 1'b1;
			end
		end
	end

	always_comb begin
		out_push             = retire;
		out_item.static_hit  = item_s2.static_hit;
		out_item.global_hit  = item_s2.global_hit;
		out_item.one_bit_hit = one_bit_hit;
		out_item.two_bit_hit = two_bit_hit;
		out_item.target_hit  = target_hit;
		out_item.total       = total_q + 1'b1;
		out_item.static_cnt  = static_q + CNT_W'(item_s2.static_hit);
		out_item.global_cnt  = global_q + CNT_W'(item_s2.global_hit);
		out_item.one_bit_cnt = one_bit_q + CNT_W'(one_bit_hit);
		out_item.two_bit_cnt = two_bit_q + CNT_W'(two_bit_hit);
		out_item.target_cnt  = target_q + CNT_W'(target_hit);
	end

	// table storage: clear sweep, update write, registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= ENTRY_INIT;
		end else if (retire) begin
			mem[idx_s2] <= upd;
		end
		if (load) begin
			rdata_s2 <= mem[in_idx];
		end
	end

	// hold the write that lands with the read, forward it to the next item
	always_ff @(posedge clk) begin
		if (load) begin
			item_s2    <= in_item;
			idx_s2     <= in_idx;
			fwd_idx_q  <= idx_s2;
			fwd_data_q <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s2    <= 1'b0;
			fwd_valid_q <= 1'b0;
			total_q     <= '0;
			static_q    <= '0;
			global_q    <= '0;
			one_bit_q   <= '0;
			two_bit_q   <= '0;
			target_q    <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_MASK) begin
					clearing_q <= 1'b0;
				end
			end
			if (load) begin
				valid_s2    <= 1'b1;
				fwd_valid_q <= retire;
			end else if (retire) begin
				valid_s2 <= 1'b0;
			end
			if (retire) begin
				total_q   <= out_item.total;
				static_q  <= out_item.static_cnt;
				global_q  <= out_item.global_cnt;
				one_bit_q <= out_item.one_bit_cnt;
				two_bit_q <= out_item.two_bit_cnt;
				target_q  <= out_item.target_cnt;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/branch_predictor_accuracy_bank_core.sv
// Top level of the branch predictor accuracy bank.
//
//   Channel   Direction  Handshake            Payload
//   branch    in         push / full          branch_pc, was_taken, branch_target
//   result    out        pop / empty          five hit flags, six running counts
//
// One branch per cycle sustained while results are popped and no clear runs;
// a branch passes the front queue, then the table read into the back stage,
// then the result queue. The table takes one read and one write each cycle;
// back-to-back hits on one index are forwarded from the pending write.
// After reset the table is swept entry by entry to its initial values, and
// full stays high meanwhile.
// A stalled result side fills the result queue, then the back stage, then
// the front queue before full rises.
`default_nettype none

module branch_predictor_accuracy_bank_core #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	output logic                            full,
	input  wire  [bpab_pkg::PC_W-1:0]       branch_pc,
	input  wire                             was_taken,
	input  wire  [bpab_pkg::TGT_W-1:0]      branch_target,
	output logic                            empty,
	input  wire                             pop,
	output logic                            static_hit,
	output logic                            global_hit,
	output logic                            one_bit_hit,
	output logic                            two_bit_hit,
	output logic                            target_hit,
	output logic [bpab_pkg::CNT_W-1:0]      total_branches,
	output logic [bpab_pkg::CNT_W-1:0]      static_count,
	output logic [bpab_pkg::CNT_W-1:0]      global_count,
	output logic [bpab_pkg::CNT_W-1:0]      one_bit_count,
	output logic [bpab_pkg::CNT_W-1:0]      two_bit_count,
	output logic [bpab_pkg::CNT_W-1:0]      target_count
);

	import bpab_pkg::*;

	logic           mid_push;
	front_item_t    mid_push_item;
	logic           mid_full;
	front_item_t    mid_pop_item;
	logic           mid_empty;
	back_status_t   back_status;
	logic           res_push;
	result_t        res_push_item;
	logic           res_full;
	result_t        res_item;

	bpab_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.branch_pc     (branch_pc),
		.was_taken     (was_taken),
		.branch_target (branch_target),
		.mid_full      (mid_full),
		.clearing      (back_status.clearing),
		.mid_push      (mid_push),
		.mid_item      (mid_push_item)
	);

	bpab_fifo #(
		.item_t (front_item_t),
		.DEPTH  (FIFO_DEPTH)
	) u_mid_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mid_push),
		.push_item (mid_push_item),
		.full      (mid_full),
		.pop       (back_status.in_pop),
		.pop_item  (mid_pop_item),
		.empty     (mid_empty)
	);

	bpab_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_item  (mid_pop_item),
		.status   (back_status),
		.out_full (res_full),
		.out_push (res_push),
		.out_item (res_push_item)
	);

	bpab_fifo #(
		.item_t (result_t),
		.DEPTH  (FIFO_DEPTH)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_item (res_push_item),
		.full      (res_full),
		.pop       (pop),
		.pop_item  (res_item),
		.empty     (empty)
	);

	always_comb begin
		static_hit     = res_item.static_hit;
		global_hit     = res_item.global_hit;
		one_bit_hit    = res_item.one_bit_hit;
		two_bit_hit    = res_item.two_bit_hit;
		target_hit     = res_item.target_hit;
		total_branches = res_item.total;
		static_count   = res_item.static_cnt;
		global_count   = res_item.global_cnt;
		one_bit_count  = res_item.one_bit_cnt;
		two_bit_count  = res_item.two_bit_cnt;
		target_count   = res_item.target_cnt;
	end

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.clearing |-> full)
		else $error("item accepted during table clear");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.in_pop |-> !mid_empty && !back_status.clearing)
		else $error("back stage took an item from an empty queue");

	a_clear_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(back_status.clearing) |-> mid_empty && empty)
		else $error("items in flight when table clear finished");

	a_no_result_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

endmodule

`default_nettype wire

FILE: dv/branch_predictor_accuracy_bank_core_test.sv
// Self-checking testbench for the branch predictor accuracy bank core.
`default_nettype none

module branch_predictor_accuracy_bank_core_test;
	import bpab_pkg::*;

	localparam int TABLE_ENTRIES = 1024;
	localparam int HOT_SLOTS     = 8;
	localparam int PHASE_ITEMS   = 160;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TAIL_CYCLES   = 8;

	typedef struct packed {
		logic [PC_W-1:0]  pc;
		logic             taken;
		logic [TGT_W-1:0] target;
	} branch_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [PC_W-1:0]      branch_pc;
	logic                 was_taken;
	logic [TGT_W-1:0]     branch_target;
	logic                 empty;
	logic                 pop;
	logic                 static_hit;
	logic                 global_hit;
	logic                 one_bit_hit;
	logic                 two_bit_hit;
	logic                 target_hit;
	logic [CNT_W-1:0]     total_branches;
	logic [CNT_W-1:0]     static_count;
	logic [CNT_W-1:0]     global_count;
	logic [CNT_W-1:0]     one_bit_count;
	logic [CNT_W-1:0]     two_bit_count;
	logic [CNT_W-1:0]     target_count;

	branch_t              branch_q[$];
	result_t              score_q[$];
	logic                 took_branch;
	int                   send_idle_pct;
	int                   pop_stall_pct;
	int                   mismatches;

	// predictor state
	logic                 last_taken;
	logic                 one_bit_tab [TABLE_ENTRIES];
	logic [CTR_W-1:0]     ctr_tab [TABLE_ENTRIES];
	logic [TGT_W-1:0]     tgt_tab [TABLE_ENTRIES];
	logic [CNT_W-1:0]     branch_cnt;
	logic [CNT_W-1:0]     static_cnt;
	logic [CNT_W-1:0]     global_cnt;
	logic [CNT_W-1:0]     one_bit_cnt;
	logic [CNT_W-1:0]     two_bit_cnt;
	logic [CNT_W-1:0]     target_cnt;

	// frequently revisited table entries and their behavior
	int                   hot_idx [HOT_SLOTS] = '{0, TABLE_ENTRIES - 1, 1, 5, 512, 341, 682, 100};
	int                   hot_bias [HOT_SLOTS] = '{90, 10, 50, 75, 25, 95, 5, 60};
	logic [TGT_W-1:0]     hot_tgt [HOT_SLOTS][2];

	branch_predictor_accuracy_bank_core #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.branch_pc(branch_pc),
		.was_taken(was_taken),
		.branch_target(branch_target),
		.empty(empty),
		.pop(pop),
		.static_hit(static_hit),
		.global_hit(global_hit),
		.one_bit_hit(one_bit_hit),
		.two_bit_hit(two_bit_hit),
		.target_hit(target_hit),
		.total_branches(total_branches),
		.static_count(static_count),
		.global_count(global_count),
		.one_bit_count(one_bit_count),
		.two_bit_count(two_bit_count),
		.target_count(target_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	task automatic score_branch(input logic [PC_W-1:0] pc, input logic taken,
			input logic [TGT_W-1:0] target);
		int      idx;
		result_t r;
		idx = int'(pc & PC_W'(TABLE_ENTRIES - 1));
		r = '0;
		r.static_hit  = taken;
		r.global_hit  = (last_taken == taken);
		r.one_bit_hit = (one_bit_tab[idx] == taken);
		r.two_bit_hit = ((ctr_tab[idx] >= CTR_WEAK_TAKEN) == taken);
		r.target_hit  = (tgt_tab[idx] == target);
		last_taken = taken;
		one_bit_tab[idx] = taken;
		if (taken && ctr_tab[idx] != CTR_MAX) begin
			ctr_tab[idx] = ctr_tab[idx] + 1'b1;
		end else if (!taken && ctr_tab[idx] != CTR_MIN) begin
			ctr_tab[idx] = ctr_tab[idx] - 1'b1;
		end
		if (!r.target_hit) begin
			tgt_tab[idx] = target;
		end
		branch_cnt  = branch_cnt + CNT_W'(1);
		static_cnt  = static_cnt + CNT_W'(r.static_hit);
		global_cnt  = global_cnt + CNT_W'(r.global_hit);
		one_bit_cnt = one_bit_cnt + CNT_W'(r.one_bit_hit);
		two_bit_cnt = two_bit_cnt + CNT_W'(r.two_bit_hit);
		target_cnt  = target_cnt + CNT_W'(r.target_hit);
		r.total       = branch_cnt;
		r.static_cnt  = static_cnt;
		r.global_cnt  = global_cnt;
		r.one_bit_cnt = one_bit_cnt;
		r.two_bit_cnt = two_bit_cnt;
		r.target_cnt  = target_cnt;
		score_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
			end
		end
	endtask

	task automatic check_result();
		result_t r;
		if (score_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result item with none expected: total %0h", total_branches);
			end
		end else begin
			r = score_q.pop_front();
			check_field("static_hit", CNT_W'(r.static_hit), CNT_W'(static_hit));
			check_field("global_hit", CNT_W'(r.global_hit), CNT_W'(global_hit));
			check_field("one_bit_hit", CNT_W'(r.one_bit_hit), CNT_W'(one_bit_hit));
			check_field("two_bit_hit", CNT_W'(r.two_bit_hit), CNT_W'(two_bit_hit));
			check_field("target_hit", CNT_W'(r.target_hit), CNT_W'(target_hit));
			check_field("total_branches", r.total, total_branches);
			check_field("static_count", r.static_cnt, static_count);
			check_field("global_count", r.global_cnt, global_count);
			check_field("one_bit_count", r.one_bit_cnt, one_bit_count);
			check_field("two_bit_count", r.two_bit_cnt, two_bit_count);
			check_field("target_count", r.target_cnt, target_count);
		end
	endtask

	// sample handshakes, predict and check
	always @(posedge clk) begin
		took_branch <= push && !full;
		if (push && !full) begin
			score_branch(branch_pc, was_taken, branch_target);
		end
		if (pop && !empty) begin
			check_result();
		end
	end

	// drive the branch side and the result side
	always @(negedge clk) begin
		branch_t b;
		if (arst_n) begin
			if (took_branch) begin
				void'(branch_q.pop_front());
			end
			if (!push || took_branch) begin
				if (branch_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					b = branch_q[0];
					push          <= 1'b1;
					branch_pc     <= b.pc;
					was_taken     <= b.taken;
					branch_target <= b.target;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	task automatic add_branch(input logic [PC_W-1:0] pc, input logic taken,
			input logic [TGT_W-1:0] target);
		branch_t b;
		b.pc     = pc;
		b.taken  = taken;
		b.target = target;
		branch_q.push_back(b);
	endtask

	task automatic add_random_branch();
		int               mode;
		int               s;
		logic [PC_W-1:0]  pc;
		logic [TGT_W-1:0] target;
		mode = $urandom_range(99);
		if (mode < 75) begin
			s = $urandom_range(HOT_SLOTS - 1);
			pc = (PC_W'($urandom) & ~PC_W'(TABLE_ENTRIES - 1)) | PC_W'(hot_idx[s]);
			if ($urandom_range(99) < 85) begin
				target = hot_tgt[s][$urandom_range(1)];
			end else begin
				target = $urandom;
			end
			add_branch(pc, $urandom_range(99) < hot_bias[s], target);
		end else if (mode < 90) begin
			add_branch(PC_W'($urandom), 1'($urandom), $urandom);
		end else begin
			pc = $urandom_range(1) ? '1 : '0;
			target = $urandom_range(1) ? '1 : '0;
			add_branch(pc, 1'($urandom), target);
		end
	endtask

	task automatic wait_sent();
		while (branch_q.size() != 0 || push) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int i;
		int p;
		int idle_pct [4];
		int stall_pct [4];
		idle_pct      = '{0, 61, 0, 11};
		stall_pct     = '{0, 0, 61, 11};
		push          = 1'b0;
		pop           = 1'b0;
		branch_pc     = '0;
		was_taken     = 1'b0;
		branch_target = '0;
		took_branch   = 1'b0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		mismatches    = 0;
		last_taken    = 1'b1;
		branch_cnt    = '0;
		static_cnt    = '0;
		global_cnt    = '0;
		one_bit_cnt   = '0;
		two_bit_cnt   = '0;
		target_cnt    = '0;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			one_bit_tab[i] = 1'b1;
			ctr_tab[i]     = CTR_WEAK_TAKEN;
			tgt_tab[i]     = '0;
		end
		for (i = 0; i < HOT_SLOTS; i++) begin
			hot_tgt[i][0] = $urandom;
			hot_tgt[i][1] = $urandom;
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// table extremes, counter saturation at the taken end, high address bits ignored
		add_branch('0, 1'b1, '0);
		add_branch('0, 1'b0, '1);
		add_branch('0, 1'b0, '1);
		add_branch('0, 1'b0, '1);
		add_branch('0, 1'b1, '0);
		add_branch('1, 1'b1, '1);
		add_branch('1, 1'b1, '1);
		add_branch('1, 1'b1, '1);
		add_branch('1, 1'b1, '1);
		add_branch('1, 1'b0, '0);
		add_branch(PC_W'(TABLE_ENTRIES), 1'b1, 32'h0000_0000);
		add_branch(PC_W'('1) & ~PC_W'(TABLE_ENTRIES - 1), 1'b1, 32'h0000_0000);
		add_branch(PC_W'(TABLE_ENTRIES - 1), 1'b0, 32'h5555_5555);
		add_branch(PC_W'(5), 1'b0, 32'hAAAA_AAAA);
		add_branch(PC_W'(5), 1'b1, 32'hAAAA_AAAA);
		add_branch(PC_W'(5), 1'b0, 32'h5555_5555);
		add_branch(PC_W'(5), 1'b1, 32'h5555_5555);
		add_branch(PC_W'(5) | PC_W'(TABLE_ENTRIES * 3), 1'b1, 32'h5555_5555);
		add_branch(PC_W'(6), 1'b0, 32'h8000_0001);
		add_branch(PC_W'(6), 1'b0, 32'h8000_0001);
		wait_sent();

		for (p = 0; p < 4; p++) begin
			send_idle_pct = idle_pct[p];
			pop_stall_pct = stall_pct[p];
			for (i = 0; i < PHASE_ITEMS; i++) begin
				add_random_branch();
			end
			wait_sent();
		end

		for (i = 0; i < DRAIN_LIMIT && score_q.size() != 0; i++) begin
			@(posedge clk);
		end
		if (score_q.size() != 0) begin
			mismatches++;
			$display("%0d result items never arrived", score_q.size());
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
